>>> hdl/aeas_pkg.sv
package aeas_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int COL_BITS   = $clog2(MAX_COLS);
    localparam int CNT_BITS   = COL_BITS + 1;
    localparam int MAX_ROWS   = 65535;
    localparam int ROW_BITS   = 16;
    localparam int SCORE_BITS = 21;
    localparam int BEST_BITS  = 20;
    localparam int SYM_BITS   = 8;
    localparam int PEN_BITS   = 8;
    localparam int ACC_BITS   = 25;
    localparam int WIDE_BITS  = 28;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;

    localparam logic [2:0] REG_GAP_OPEN      = 3'd0;
    localparam logic [2:0] REG_GAP_EXTEND    = 3'd1;
    localparam logic [2:0] REG_MATCH_SCORE   = 3'd2;
    localparam logic [2:0] REG_MISMATCH_SCORE = 3'd3;
    localparam logic [2:0] REG_B_LENGTH      = 3'd4;

    localparam logic CMD_LOAD_B = 1'b0;
    localparam logic CMD_ROW    = 1'b1;

    typedef logic signed [SCORE_BITS-1:0] score_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;

    localparam wide_t SC_MAX_W = wide_t'(2 ** (SCORE_BITS - 1) - 1);
    localparam wide_t SC_MIN_W = wide_t'(-(2 ** (SCORE_BITS - 1)));

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ROW,
        S_DRAIN,
        S_REPORT,
        S_CLEAR
    } state_t;

    typedef struct packed {
        logic                cmd;
        logic [SYM_BITS-1:0] symbol;
        logic                last;
    } item_t;

    typedef struct packed {
        logic [BEST_BITS-1:0] best_score;
        logic [ROW_BITS-1:0]  end_row;
        logic [CNT_BITS-1:0]  end_col;
    } result_t;

    typedef struct packed {
        score_t hz;
        score_t gb;
    } score_entry_t;

    function automatic score_t sat_score(input wide_t x);
        score_t r;
        if (x > SC_MAX_W)
        begin
            r = score_t'(SC_MAX_W);
        end
        else if (x < SC_MIN_W)
        begin
            r = score_t'(SC_MIN_W);
        end
        else
        begin
            r = score_t'(x);
        end
        return r;
    endfunction

    function automatic wide_t widen(input score_t s);
        return wide_t'(s);
    endfunction

    function automatic wide_t pen(input logic [PEN_BITS-1:0] p);
        return wide_t'(p);
    endfunction

    // affine gap step: extend the run or open a new one from the cell value
    function automatic score_t gap_step(input score_t g, input score_t h,
                                        input logic [PEN_BITS-1:0] q,
                                        input logic [PEN_BITS-1:0] r);
        score_t res;
        if (widen(g) >= widen(h) - pen(q))
        begin
            res = sat_score(widen(g) - pen(r));
        end
        else
        begin
            res = sat_score(widen(h) - pen(q) - pen(r));
        end
        return res;
    endfunction

endpackage

>>> hdl/affine_extension_align_score_top.sv
// channel    direction  handshake                      payload
// item       in         start high while busy is low   item_t {cmd, symbol, last}
// result     out        done high for one cycle        result_t {best_score, end_row, end_col}
// apb        in/out     psel, penable, pwrite, pready  5 registers at 4-byte steps
//
// after reset busy stays high while the score memory is cleared
// a B load writes the next symbol slot; an A symbol runs b_length columns (b_length capped at 1024),
// one column per cycle through the score memory read-modify-write pipeline plus drain
// the first A symbol of a run sweeps the boundary values into the score memory first
// a last A symbol then puts the result on done, which cannot be held off
// rst_n is asynchronous; symbol memory content is undefined until loaded
module affine_extension_align_score_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  aeas_pkg::item_t                     item,
    output logic                                done,
    output aeas_pkg::result_t                   result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aeas_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [aeas_pkg::DATA_BITS-1:0]      pwdata,
    output logic [aeas_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready
);
    import aeas_pkg::*;

    logic [PEN_BITS-1:0]        gap_open_reg;
    logic [PEN_BITS-1:0]        gap_extend_reg;
    logic signed [PEN_BITS-1:0] match_reg;
    logic signed [PEN_BITS-1:0] mismatch_reg;
    logic [CNT_BITS-1:0]        b_length_reg;

    state_t                     state_reg;
    state_t                     state_next;
    logic [CNT_BITS-1:0]        load_index_reg;
    logic [ROW_BITS-1:0]        row_index_reg;
    logic [CNT_BITS-1:0]        rd_col_reg;
    logic [CNT_BITS-1:0]        init_col_reg;
    logic [ACC_BITS-1:0]        init_t_reg;
    logic                       s1_valid_reg;
    logic                       s2_valid_reg;
    logic                       s3_valid_reg;
    logic [BEST_BITS-1:0]       best_reg;
    logic [ROW_BITS-1:0]        best_row_reg;
    logic [CNT_BITS-1:0]        best_col_reg;

    logic [SYM_BITS-1:0]        a_reg;
    logic                       last_reg;
    score_t                     diag_reg;
    score_t                     left_reg;
    score_t                     gap_a_reg;
    logic [COL_BITS-1:0]        s1_col_reg;
    logic [COL_BITS-1:0]        s2_col_reg;
    score_t                     s2_gb_reg;
    score_t                     s2_m_reg;
    logic [COL_BITS-1:0]        s3_col_reg;
    score_t                     s3_cell_reg;

    logic [SYM_BITS-1:0]        seq_b_mem [MAX_COLS];
    logic [SYM_BITS-1:0]        seq_b_rd_reg;
    score_entry_t               score_mem [MAX_COLS];
    score_entry_t               score_rd_reg;

    logic                       cfg_write;
    logic [2:0]                 cfg_idx;
    logic [CNT_BITS-1:0]        n_cols;
    logic                       accept;
    logic                       row_item;
    logic                       run_start;
    logic                       row_setup;
    logic                       init_we;
    logic                       clear_we;
    logic                       issue;
    logic                       b_we;
    logic                       pipe_busy;

    wide_t                      row_t;
    score_t                     bnd_cell;
    score_t                     bnd_gap;
    score_entry_t               init_entry;
    score_entry_t               sc_wdata;
    logic                       sc_we;
    logic [COL_BITS-1:0]        sc_waddr;

    score_t                     gb_new;
    score_t                     cand;
    score_t                     m_val;
    logic signed [PEN_BITS-1:0] sub;
    score_t                     ga_new;
    score_t                     cell_val;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = paddr[ADDR_BITS-1:2];
    assign n_cols    = (b_length_reg > CNT_BITS'(MAX_COLS)) ? CNT_BITS'(MAX_COLS)
                                                              : b_length_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_open_reg   <= PEN_BITS'(10);
            gap_extend_reg <= PEN_BITS'(1);
            match_reg      <= PEN_BITS'(2);
            mismatch_reg   <= -PEN_BITS'(3);
            b_length_reg   <= CNT_BITS'(MAX_COLS);
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_GAP_OPEN:       gap_open_reg   <= pwdata[PEN_BITS-1:0];
                REG_GAP_EXTEND:     gap_extend_reg <= pwdata[PEN_BITS-1:0];
                REG_MATCH_SCORE:    match_reg      <= pwdata[PEN_BITS-1:0];
                REG_MISMATCH_SCORE: mismatch_reg   <= pwdata[PEN_BITS-1:0];
                REG_B_LENGTH:       b_length_reg   <= pwdata[CNT_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_GAP_OPEN:       prdata = DATA_BITS'(gap_open_reg);
            REG_GAP_EXTEND:     prdata = DATA_BITS'(gap_extend_reg);
            REG_MATCH_SCORE:    prdata = DATA_BITS'($unsigned(match_reg));
            REG_MISMATCH_SCORE: prdata = DATA_BITS'($unsigned(mismatch_reg));
            REG_B_LENGTH:       prdata = DATA_BITS'(b_length_reg);
            default:            prdata = '0;
        endcase
    end

    assign pipe_busy = s1_valid_reg | s2_valid_reg | s3_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (init_col_reg == CNT_BITS'(MAX_COLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start && item.cmd == CMD_ROW)
                begin
                    if (row_index_reg == '0)
                    begin
                        state_next = S_INIT;
                    end
                    else if (row_index_reg < ROW_BITS'(MAX_ROWS))
                    begin
                        state_next = S_ROW;
                    end
                    else if (item.last)
                    begin
                        state_next = S_REPORT;
                    end
                end
            end
            S_INIT:
            begin
                if (init_col_reg + CNT_BITS'(1) >= n_cols)
                begin
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                if (rd_col_reg + CNT_BITS'(1) >= n_cols)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = last_reg ? S_REPORT : S_IDLE;
                end
            end
            S_REPORT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        busy      = (state_reg != S_IDLE);
        done      = (state_reg == S_REPORT);
        accept    = start & (state_reg == S_IDLE);
        row_item  = accept & (item.cmd == CMD_ROW);
        b_we      = accept & (item.cmd == CMD_LOAD_B) & (load_index_reg < CNT_BITS'(MAX_COLS));
        run_start = row_item & (row_index_reg == '0);
        row_setup = (state_reg != S_ROW) && (state_next == S_ROW);
        init_we   = (state_reg == S_INIT) && (init_col_reg < n_cols);
        clear_we  = (state_reg == S_CLEAR);
        issue     = (state_reg == S_ROW) && (rd_col_reg < n_cols);
    end

    assign result.best_score = best_reg;
    assign result.end_row    = best_row_reg;
    assign result.end_col    = best_col_reg;

    // boundaries
    always_comb
    begin
        row_t            = pen(gap_open_reg)
                         + wide_t'(ACC_BITS'(gap_extend_reg)
                                   * ACC_BITS'(row_index_reg + ROW_BITS'(1)));
        bnd_cell         = sat_score(-row_t);
        bnd_gap          = sat_score(-(row_t + pen(gap_open_reg)));
        init_entry.hz    = sat_score(-wide_t'(init_t_reg));
        init_entry.gb    = sat_score(-(wide_t'(init_t_reg) + pen(gap_open_reg)));
    end

    // stage 1: column from memory, gap in B and diagonal candidate
    always_comb
    begin
        gb_new = gap_step(score_rd_reg.gb, score_rd_reg.hz, gap_open_reg, gap_extend_reg);
        sub    = (seq_b_rd_reg == a_reg) ? match_reg : mismatch_reg;
        cand   = sat_score(widen(diag_reg) + wide_t'(sub));
        m_val  = (gb_new > cand) ? gb_new : cand;
    end

    // stage 2: gap in A along the row and the cell value
    always_comb
    begin
        ga_new   = gap_step(gap_a_reg, left_reg, gap_open_reg, gap_extend_reg);
        cell_val = (ga_new > s2_m_reg) ? ga_new : s2_m_reg;
    end

    always_comb
    begin
        sc_we    = clear_we | init_we | s2_valid_reg;
        sc_waddr = (clear_we | init_we) ? init_col_reg[COL_BITS-1:0] : s2_col_reg;
        if (clear_we)
        begin
            sc_wdata = '0;
        end
        else if (init_we)
        begin
            sc_wdata = init_entry;
        end
        else
        begin
            sc_wdata.hz = cell_val;
            sc_wdata.gb = s2_gb_reg;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            seq_b_mem[load_index_reg[COL_BITS-1:0]] <= item.symbol;
        end
        seq_b_rd_reg <= seq_b_mem[rd_col_reg[COL_BITS-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (sc_we)
        begin
            score_mem[sc_waddr] <= sc_wdata;
        end
        score_rd_reg <= score_mem[rd_col_reg[COL_BITS-1:0]];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            load_index_reg <= '0;
            row_index_reg  <= '0;
            rd_col_reg     <= '0;
            init_col_reg   <= '0;
            init_t_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            best_reg       <= '0;
            best_row_reg   <= '0;
            best_col_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (b_we)
            begin
                load_index_reg <= load_index_reg + CNT_BITS'(1);
            end
            if (run_start)
            begin
                init_col_reg <= '0;
                init_t_reg   <= ACC_BITS'(gap_open_reg) + ACC_BITS'(gap_extend_reg);
                best_reg     <= '0;
                best_row_reg <= '0;
                best_col_reg <= '0;
            end
            else if (init_we)
            begin
                init_col_reg <= init_col_reg + CNT_BITS'(1);
                init_t_reg   <= init_t_reg + ACC_BITS'(gap_extend_reg);
            end
            else if (clear_we)
            begin
                init_col_reg <= init_col_reg + CNT_BITS'(1);
            end
            if (row_setup)
            begin
                row_index_reg <= row_index_reg + ROW_BITS'(1);
                rd_col_reg    <= '0;
            end
            else if (issue)
            begin
                rd_col_reg <= rd_col_reg + CNT_BITS'(1);
            end
            if (s3_valid_reg && (s3_cell_reg > $signed({1'b0, best_reg})))
            begin
                best_reg     <= s3_cell_reg[BEST_BITS-1:0];
                best_row_reg <= row_index_reg;
                best_col_reg <= CNT_BITS'(s3_col_reg) + CNT_BITS'(1);
            end
            if (state_reg == S_REPORT)
            begin
                row_index_reg  <= '0;
                load_index_reg <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (row_item)
        begin
            a_reg    <= item.symbol;
            last_reg <= item.last;
        end
        s1_col_reg  <= rd_col_reg[COL_BITS-1:0];
        s2_col_reg  <= s1_col_reg;
        s2_gb_reg   <= gb_new;
        s2_m_reg    <= m_val;
        s3_col_reg  <= s2_col_reg;
        s3_cell_reg <= cell_val;
        if (row_setup)
        begin
            left_reg  <= bnd_cell;
            diag_reg  <= bnd_cell;
            gap_a_reg <= bnd_gap;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                diag_reg <= score_rd_reg.hz;
            end
            if (s2_valid_reg)
            begin
                left_reg  <= cell_val;
                gap_a_reg <= ga_new;
            end
        end
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pipe_busy)
        else $error("pipeline not drained while idle");

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> !init_we)
        else $error("boundary sweep and cell write collide");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_index_reg <= CNT_BITS'(MAX_COLS))
        else $error("load index past memory depth");

    a_row_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        row_setup |=> (left_reg == diag_reg) && !pipe_busy)
        else $error("row boundary not loaded cleanly");

endmodule

>>> test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aeas_pkg::*;

    localparam longint SCORE_HI      = (longint'(1) <<< (SCORE_BITS - 1)) - 1;
    localparam longint SCORE_LO      = -SCORE_HI - 1;
    localparam int     SETTLE_CYCLES = 2 * MAX_COLS + 16;
    localparam int     RANDOM_ITEMS  = 545;

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 start   = 1'b0;
    logic                 busy;
    item_t                item    = '0;
    logic                 done;
    result_t              result;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [DATA_BITS-1:0] pwdata  = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    // shadow of the block's registers and alignment state
    logic [PEN_BITS-1:0]        cfg_open     = 8'd10;
    logic [PEN_BITS-1:0]        cfg_extend   = 8'd1;
    logic signed [SYM_BITS-1:0] cfg_match    = 8'sd2;
    logic signed [SYM_BITS-1:0] cfg_mismatch = -8'sd3;
    logic [CNT_BITS-1:0]        cfg_len      = 11'd1024;

    logic [SYM_BITS-1:0]  b_sym [MAX_COLS];
    score_t               prev_row [MAX_COLS];
    score_t               gap_col [MAX_COLS];
    int unsigned          rows_done = 0;
    int unsigned          load_ptr  = 0;
    logic [BEST_BITS-1:0] top_score = '0;
    logic [ROW_BITS-1:0]  top_row   = '0;
    logic [CNT_BITS-1:0]  top_col   = '0;

    result_t expected_scores [$];
    item_t   command_queue [$];

    int          items_queued   = 0;
    int          items_issued   = 0;
    int          items_accepted = 0;
    int          error_count    = 0;
    int          burst_left     = 1;
    int          idle_left      = 0;
    bit          steady_feed    = 1'b0;
    logic [7:0]  sym_base       = '0;
    int          sym_span       = 256;

    affine_extension_align_score_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic score_t clamp_score(input longint x);
        longint y;
        y = x;
        if (y > SCORE_HI)
        begin
            y = SCORE_HI;
        end
        else if (y < SCORE_LO)
        begin
            y = SCORE_LO;
        end
        return score_t'(y);
    endfunction

    function automatic int active_cols();
        return (cfg_len > MAX_COLS) ? MAX_COLS : int'(cfg_len);
    endfunction

    function automatic void load_boundaries();
        int     n;
        int     j;
        longint q;
        longint r;
        longint t;
        n = active_cols();
        q = cfg_open;
        r = cfg_extend;
        for (j = 0; j < n; j++)
        begin
            t = q + r * longint'(j + 1);
            prev_row[j] = clamp_score(-t);
            gap_col[j]  = clamp_score(-(t + q));
        end
        top_score = '0;
        top_row   = '0;
        top_col   = '0;
    endfunction

    function automatic void score_row(input int unsigned row, input logic [7:0] a_sym);
        int     n;
        int     j;
        longint q;
        longint r;
        longint t;
        longint ga;
        longint lc;
        longint dg;
        longint hz;
        longint gb;
        longint sub;
        longint cell_val;
        n  = active_cols();
        q  = cfg_open;
        r  = cfg_extend;
        t  = q + r * longint'(row);
        lc = clamp_score(-t);
        dg = lc;
        ga = clamp_score(-(t + q));
        for (j = 0; j < n; j++)
        begin
            hz = prev_row[j];
            gb = gap_col[j];
            if (ga >= lc - q)
            begin
                ga = clamp_score(ga - r);
            end
            else
            begin
                ga = clamp_score(lc - q - r);
            end
            if (gb >= hz - q)
            begin
                gb = clamp_score(gb - r);
            end
            else
            begin
                gb = clamp_score(hz - q - r);
            end
            gap_col[j] = score_t'(gb);
            sub = (b_sym[j] == a_sym) ? cfg_match : cfg_mismatch;
            cell_val = clamp_score(dg + sub);
            if (gb > cell_val)
            begin
                cell_val = gb;
            end
            if (ga > cell_val)
            begin
                cell_val = ga;
            end
            dg = hz;
            prev_row[j] = score_t'(cell_val);
            lc = cell_val;
            if (cell_val > longint'(top_score))
            begin
                top_score = BEST_BITS'(cell_val);
                top_row   = ROW_BITS'(row);
                top_col   = CNT_BITS'(j + 1);
            end
        end
    endfunction

    function automatic void apply_item(input item_t it);
        result_t res;
        if (it.cmd == CMD_LOAD_B)
        begin
            if (load_ptr < MAX_COLS)
            begin
                b_sym[load_ptr] = it.symbol;
                load_ptr++;
            end
        end
        else
        begin
            if (rows_done == 0)
            begin
                load_boundaries();
            end
            if (rows_done < MAX_ROWS)
            begin
                rows_done++;
                score_row(rows_done, it.symbol);
            end
            if (it.last)
            begin
                res.best_score = top_score;
                res.end_row    = top_row;
                res.end_col    = top_col;
                expected_scores = {expected_scores, res};
                rows_done = 0;
                load_ptr  = 0;
            end
        end
    endfunction

    function automatic void queue_item(input logic cmd, input logic [7:0] sym,
                                       input logic last);
        item_t it;
        it.cmd    = cmd;
        it.symbol = sym;
        it.last   = last;
        command_queue = {command_queue, it};
        items_queued++;
    endfunction

    function automatic logic [7:0] pick_symbol();
        return 8'(sym_base + $urandom_range(0, sym_span - 1));
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < 40)
        begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
        error_count++;
    endtask

    task automatic settle();
        while (items_accepted != items_queued)
            @(posedge clk);
        while (expected_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] q, input logic [7:0] r,
                              input logic signed [7:0] m, input logic signed [7:0] mm,
                              input logic [10:0] len);
        logic [DATA_BITS-1:0] value [5];
        logic [2:0]           index [5];
        int                   i;
        value = '{{24'b0, q}, {24'b0, r}, {24'b0, m}, {24'b0, mm}, {21'b0, len}};
        index = '{REG_GAP_OPEN, REG_GAP_EXTEND, REG_MATCH_SCORE, REG_MISMATCH_SCORE,
                  REG_B_LENGTH};
        for (i = 0; i < 5; i++)
        begin
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {index[i], 2'b00};
            pwdata  <= value[i];
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
        cfg_open     = q;
        cfg_extend   = r;
        cfg_match    = m;
        cfg_mismatch = mm;
        cfg_len      = len;
    endtask

    // sender: bursts of transactions separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!start || items_accepted == items_issued))
        begin
            if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (command_queue.size() != 0)
            begin
                item  <= command_queue.pop_front();
                start <= 1'b1;
                items_issued++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    if (steady_feed || $urandom_range(0, 2) == 0)
                    begin
                        idle_left = 0;
                    end
                    else
                    begin
                        idle_left = $urandom_range(1, 24);
                    end
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_scores.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result score %0d row %0d col %0d",
                                              result.best_score, result.end_row,
                                              result.end_col));
                end
                else
                begin
                    want = expected_scores.pop_front();
                    if (result.best_score !== want.best_score)
                    begin
                        report_mismatch($sformatf("best_score %0d, expected %0d",
                                                  result.best_score, want.best_score));
                    end
                    if (result.end_row !== want.end_row)
                    begin
                        report_mismatch($sformatf("end_row %0d, expected %0d",
                                                  result.end_row, want.end_row));
                    end
                    if (result.end_col !== want.end_col)
                    begin
                        report_mismatch($sformatf("end_col %0d, expected %0d",
                                                  result.end_col, want.end_col));
                    end
                end
            end
            if (start && !busy)
            begin
                apply_item(item);
                items_accepted++;
            end
        end
    end

    initial
    begin : stimulus
        int                phase_start;
        int                runs;
        int                run_i;
        int                rows;
        int                loads;
        int                k;
        int                cols;
        int                pick;
        int                fill_mark;
        bit                big;
        logic [7:0]        q;
        logic [7:0]        r;
        logic signed [7:0] m;
        logic signed [7:0] mm;
        logic [10:0]       len;

        fill_mark = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset penalties, more loads than columns, back to back rows
        steady_feed = 1'b1;
        set_config(8'd10, 8'd1, 8'sd2, -8'sd3, 11'd12);
        for (k = 0; k < 14; k++)
        begin
            queue_item(CMD_LOAD_B, pick_symbol(), 1'b0);
        end
        fill_mark = 14;
        queue_item(CMD_ROW, pick_symbol(), 1'b0);
        queue_item(CMD_ROW, pick_symbol(), 1'b0);
        queue_item(CMD_ROW, pick_symbol(), 1'b1);
        settle();
        steady_feed = 1'b0;

        // extreme scores and symbol codes
        set_config(8'd0, 8'd0, 8'sd127, -8'sd128, 11'd4);
        queue_item(CMD_LOAD_B, 8'h00, 1'b0);
        queue_item(CMD_LOAD_B, 8'hFF, 1'b0);
        queue_item(CMD_LOAD_B, 8'hAA, 1'b0);
        queue_item(CMD_LOAD_B, 8'h55, 1'b0);
        queue_item(CMD_ROW, 8'h00, 1'b0);
        queue_item(CMD_ROW, 8'hFF, 1'b0);
        queue_item(CMD_ROW, 8'h55, 1'b1);
        settle();

        // no columns, largest penalties, last on a load is ignored
        set_config(8'd255, 8'd255, 8'sd1, -8'sd1, 11'd0);
        queue_item(CMD_LOAD_B, 8'h3C, 1'b1);
        queue_item(CMD_ROW, 8'h80, 1'b0);
        queue_item(CMD_ROW, 8'h7F, 1'b1);
        settle();

        // load during a run feeds the following rows
        set_config(8'd3, 8'd1, 8'sd5, -8'sd2, 11'd4);
        queue_item(CMD_LOAD_B, 8'h11, 1'b0);
        queue_item(CMD_LOAD_B, 8'h22, 1'b0);
        queue_item(CMD_LOAD_B, 8'h33, 1'b0);
        queue_item(CMD_ROW, 8'h11, 1'b0);
        queue_item(CMD_LOAD_B, 8'h44, 1'b0);
        queue_item(CMD_ROW, 8'h22, 1'b0);
        queue_item(CMD_ROW, 8'h44, 1'b1);
        settle();

        phase_start = items_queued;
        while (items_queued - phase_start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 7);
            q = (pick == 0) ? 8'hFF : (pick == 1) ? 8'($urandom_range(0, 255))
                : 8'($urandom_range(0, 12));
            pick = $urandom_range(0, 7);
            r = (pick == 0) ? 8'hFF : (pick == 1) ? 8'($urandom_range(0, 255))
                : 8'($urandom_range(0, 4));
            pick = $urandom_range(0, 7);
            m = (pick == 0) ? 8'sd127 : (pick == 1) ? -8'sd128
                : (pick == 2) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 10));
            pick = $urandom_range(0, 7);
            mm = (pick == 0) ? -8'sd128 : (pick == 1) ? 8'sd127
                : (pick == 2) ? 8'($urandom_range(0, 255)) : -8'($urandom_range(0, 10));
            pick = $urandom_range(0, 39);
            if (pick == 0)
            begin
                len = 11'd0;
            end
            else if (pick < 8)
            begin
                len = 11'($urandom_range(13, 40));
            end
            else
            begin
                len = 11'($urandom_range(1, 12));
            end
            set_config(q, r, m, mm, len);
            cols     = active_cols();
            big      = cols > 64;
            sym_base = 8'($urandom_range(0, 255));
            sym_span = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 4);
            runs     = big ? 1 : $urandom_range(2, 6);
            for (run_i = 0; run_i < runs; run_i++)
            begin
                // every column that a row reads has been loaded since reset
                loads = $urandom_range(0, ((cols > 24) ? 24 : cols) + 2);
                if (loads < cols && fill_mark < cols)
                begin
                    loads = cols;
                end
                if (loads > fill_mark)
                begin
                    fill_mark = loads;
                end
                for (k = 0; k < loads; k++)
                begin
                    queue_item(CMD_LOAD_B, pick_symbol(), 1'($urandom_range(0, 1)));
                end
                rows = $urandom_range(1, big ? 3 : 8);
                for (k = 0; k < rows; k++)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        queue_item(CMD_LOAD_B, pick_symbol(), 1'($urandom_range(0, 1)));
                    end
                    if (!big && $urandom_range(0, 11) == 0)
                    begin
                        queue_item(CMD_ROW, pick_symbol(), 1'b1);
                    end
                    queue_item(CMD_ROW, pick_symbol(), k == rows - 1);
                end
            end
            settle();
        end

        settle();
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
